// ===== hdl/mi4_pkg.sv =====
// Shared types, constants and address helper for the 4x4 matrix inverse block.
package mi4_pkg;

    localparam int MAT_N = 4 * 4;
    localparam int IDX_W = 4;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {A_HOLD, A_ELEM, A_PROD, A_COF} a_sel_t;
    typedef enum logic [1:0] {B_HOLD, B_MEM, B_C} b_sel_t;
    typedef enum logic [1:0] {S_HOLD, S_CLR, S_ADD, S_SUB} sum_op_t;

    typedef struct packed {
        logic             mem_we;
        logic [IDX_W-1:0] rd_addr;
        a_sel_t           a_sel;
        b_sel_t           b_sel;
        logic             c_ld;
        logic             mul_go;
        logic             mul_first;
        sum_op_t          sum_op;
        logic             cof_we;
        logic             cof_neg;
        logic [IDX_W-1:0] cof_addr;
        logic             det_ld;
        logic             div_ld;
        logic             div_step;
        logic             out_ld;
        logic [IDX_W-1:0] out_idx;
    } mi4_cmd_t;

    typedef struct packed {
        logic det_zero;
    } mi4_stat_t;

    // Column order of the three factors in each term of a 3x3 determinant;
    // the first three terms add, the last three subtract.
    function automatic logic [5:0] perm3(input logic [2:0] term);
        logic [5:0] p;
        case (term)
            3'd0:    p = {2'd0, 2'd1, 2'd2};
            3'd1:    p = {2'd1, 2'd2, 2'd0};
            3'd2:    p = {2'd2, 2'd0, 2'd1};
            3'd3:    p = {2'd0, 2'd2, 2'd1};
            3'd4:    p = {2'd2, 2'd1, 2'd0};
            3'd5:    p = {2'd1, 2'd0, 2'd2};
            default: p = {2'd0, 2'd1, 2'd2};
        endcase
        return p;
    endfunction

    // Store address of factor fac of term for the cofactor placed at inverse
    // position idx: drop row idx%4 and column idx/4.
    function automatic logic [IDX_W-1:0] elem_addr(input logic [IDX_W-1:0] idx,
                                                   input logic [2:0] term,
                                                   input logic [1:0] fac);
        logic [5:0] p;
        logic [1:0] c;
        logic [1:0] row;
        logic [1:0] col;
        p   = perm3(term);
        c   = p[5 - 2*fac -: 2];
        row = fac + ((fac >= idx[1:0]) ? 2'd1 : 2'd0);
        col = c + ((c >= idx[3:2]) ? 2'd1 : 2'd0);
        return {row, col};
    endfunction

endpackage

// ===== hdl/mi4_dpath.sv =====
// Datapath: element and cofactor stores, shared chunked multiplier, sums, divider.
module mi4_dpath import mi4_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    aclk,
    input  mi4_cmd_t                cmd,
    input  logic signed [VAL_W-1:0] s_element_value,
    output mi4_stat_t               stat,
    output logic signed [VAL_W-1:0] m_inverse_value,
    output logic [IDX_W-1:0]        m_element_index,
    output logic                    m_singular,
    output logic                    m_saturated,
    output logic                    m_last_element
);

    localparam int DW   = DATA_WIDTH;
    localparam int COFW = 3 * DW + 1;
    localparam int ACCW = 4 * DW + 2;
    localparam int AW   = 4 * DW;
    localparam int PPW  = 2 * DW + 1;
    localparam int MAGW = ACCW - 1;
    localparam int NUMW = COFW + 2 * FRAC_BITS;
    localparam int CMPW = (NUMW > MAGW) ? NUMW : MAGW;

    logic [DW-1:0]   mat_mem [MAT_N];
    logic [DW-1:0]   mat_rd_reg;
    logic [COFW-1:0] cof_mem [MAT_N];
    logic [COFW-1:0] cof_rd_reg;

    logic [AW-1:0]          a_reg;
    logic signed [DW-1:0]   b_reg;
    logic [DW-1:0]          c_reg;
    logic signed [PPW-1:0]  pp_reg;
    logic                   pp_first_reg;
    logic                   pp_valid_reg;
    logic [ACCW-1:0]        acc_reg;
    logic [ACCW-1:0]        sum_reg;

    logic                   det_zero_reg;
    logic                   dneg_reg;
    logic [MAGW-1:0]        dmag_reg;

    logic                   cneg_reg;
    logic                   over_reg;
    logic [MAGW-1:0]        rem_reg;
    logic [DW-1:0]          lo_reg;
    logic [DW-1:0]          q_reg;

    logic signed [VAL_W-1:0] val_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    sing_reg;
    logic                    sat_reg;
    logic                    last_reg;

    logic [DW-1:0]           chunk;
    logic signed [DW:0]      mul_a;
    logic signed [PPW-1:0]   pp_next;
    logic [ACCW-1:0]         pp_ext;
    logic [ACCW-1:0]         acc_next;
    logic [ACCW-1:0]         sum_neg;
    logic [COFW-1:0]         cof_wdata;
    logic                    cneg;
    logic [COFW-1:0]         cmag;
    logic [NUMW+DW-1:0]      num_ext;
    logic [NUMW-1:0]         top;
    logic                    over_pre;
    logic [MAGW:0]           rem2;
    logic [MAGW:0]           rem_diff;
    logic                    ge;
    logic                    qneg;
    logic                    sat;
    logic signed [DW-1:0]    qval;

    // Multiply one DW-bit chunk of A, top chunk signed, the rest unsigned.
    assign chunk   = a_reg[AW-1 -: DW];
    assign mul_a   = cmd.mul_first ? {chunk[DW-1], chunk} : {1'b0, chunk};
    assign pp_next = mul_a * b_reg;
    assign pp_ext  = ACCW'(pp_reg);
    assign acc_next = pp_first_reg ? pp_ext
                                   : {acc_reg[ACCW-DW-1:0], {DW{1'b0}}} + pp_ext;

    assign sum_neg   = ~sum_reg + 1'b1;
    assign cof_wdata = cmd.cof_neg ? sum_neg[COFW-1:0] : sum_reg[COFW-1:0];

    assign cneg     = cof_rd_reg[COFW-1];
    assign cmag     = cneg ? (~cof_rd_reg + 1'b1) : cof_rd_reg;
    assign num_ext  = {{DW{1'b0}}, cmag, {(2*FRAC_BITS){1'b0}}};
    assign top      = num_ext[NUMW+DW-1:DW];
    assign over_pre = CMPW'(top) >= CMPW'(dmag_reg);

    assign rem2     = {rem_reg, lo_reg[DW-1]};
    assign rem_diff = rem2 - {1'b0, dmag_reg};
    assign ge       = rem2 >= {1'b0, dmag_reg};

    assign qneg = (cneg_reg ^ dneg_reg) && (over_reg || (q_reg != '0));
    assign sat  = qneg ? (over_reg || (q_reg[DW-1] && (q_reg[DW-2:0] != '0)))
                       : (over_reg || q_reg[DW-1]);
    always_comb begin
        if (sat) begin
            qval = qneg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            qval = qneg ? (~q_reg + 1'b1) : q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mat_mem[cmd.rd_addr] <= s_element_value[DW-1:0];
        end
        mat_rd_reg <= mat_mem[cmd.rd_addr];
        if (cmd.cof_we) begin
            cof_mem[cmd.cof_addr] <= cof_wdata;
        end
        cof_rd_reg <= cof_mem[cmd.cof_addr];
    end

    always_ff @(posedge aclk) begin
        case (cmd.a_sel)
            A_ELEM:  a_reg <= {mat_rd_reg, {(3*DW){1'b0}}};
            A_PROD:  a_reg <= {acc_reg[2*DW-1:0], {(2*DW){1'b0}}};
            A_COF:   a_reg <= AW'($signed(cof_rd_reg));
            default: if (cmd.mul_go) a_reg <= {a_reg[AW-DW-1:0], {DW{1'b0}}};
        endcase
        case (cmd.b_sel)
            B_MEM:   b_reg <= mat_rd_reg;
            B_C:     b_reg <= c_reg;
            default: b_reg <= b_reg;
        endcase
        if (cmd.c_ld) begin
            c_reg <= mat_rd_reg;
        end
        pp_reg       <= pp_next;
        pp_first_reg <= cmd.mul_first;
        pp_valid_reg <= cmd.mul_go;
        if (pp_valid_reg) begin
            acc_reg <= acc_next;
        end
        case (cmd.sum_op)
            S_CLR:   sum_reg <= '0;
            S_ADD:   sum_reg <= sum_reg + acc_reg;
            S_SUB:   sum_reg <= sum_reg - acc_reg;
            default: sum_reg <= sum_reg;
        endcase
        if (cmd.det_ld) begin
            det_zero_reg <= (sum_reg == '0);
            dneg_reg     <= sum_reg[ACCW-1];
            dmag_reg     <= sum_reg[ACCW-1] ? sum_neg[MAGW-1:0] : sum_reg[MAGW-1:0];
        end
        if (cmd.div_ld) begin
            cneg_reg <= cneg;
            over_reg <= over_pre;
            rem_reg  <= MAGW'(top);
            lo_reg   <= num_ext[DW-1:0];
            q_reg    <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= ge ? rem_diff[MAGW-1:0] : rem2[MAGW-1:0];
            lo_reg  <= {lo_reg[DW-2:0], 1'b0};
            q_reg   <= {q_reg[DW-2:0], ge};
        end
        if (cmd.out_ld) begin
            idx_reg  <= cmd.out_idx;
            last_reg <= (cmd.out_idx == IDX_W'(MAT_N - 1));
            sing_reg <= det_zero_reg;
            if (det_zero_reg) begin
                val_reg <= '0;
                sat_reg <= 1'b0;
            end else begin
                val_reg <= VAL_W'(qval);
                sat_reg <= sat;
            end
        end
    end

    assign stat.det_zero   = det_zero_reg;
    assign m_inverse_value = val_reg;
    assign m_element_index = idx_reg;
    assign m_singular      = sing_reg;
    assign m_saturated     = sat_reg;
    assign m_last_element  = last_reg;

endmodule

// ===== hdl/mi4_ctrl.sv =====
// Controller: load, cofactor, determinant, divide and output sequencing.
module mi4_ctrl import mi4_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  mi4_stat_t stat,
    output mi4_cmd_t  cmd
);

    localparam int CW = $clog2(DATA_WIDTH);

    typedef enum logic [4:0] {
        LOAD, T1, T2, T3, T4, T5, T6, T7, T8, T9, T10, CWR,
        D1, D2, D3, D4, D5, D6, D7, D8, DLAT,
        V1, V2, VSTEP, VOUT, OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [2:0]       s_reg, s_next;
    logic [1:0]       j_reg, j_next;
    logic [CW-1:0]    step_reg, step_next;
    logic             m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == LOAD);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        s_next       = s_reg;
        j_next       = j_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        case (state_reg)
            LOAD: begin
                cmd.rd_addr = cnt_reg;
                cmd.mem_we  = s_valid;
                if (s_valid) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == IDX_W'(MAT_N - 1)) begin
                        i_next     = '0;
                        s_next     = '0;
                        state_next = T1;
                    end
                end
            end
            T1: begin
                cmd.rd_addr = elem_addr(i_reg, s_reg, 2'd0);
                if (s_reg == 3'd0) cmd.sum_op = S_CLR;
                state_next = T2;
            end
            T2: begin
                cmd.a_sel   = A_ELEM;
                cmd.rd_addr = elem_addr(i_reg, s_reg, 2'd1);
                state_next  = T3;
            end
            T3: begin
                cmd.b_sel   = B_MEM;
                cmd.rd_addr = elem_addr(i_reg, s_reg, 2'd2);
                state_next  = T4;
            end
            T4: begin
                cmd.c_ld      = 1'b1;
                cmd.mul_go    = 1'b1;
                cmd.mul_first = 1'b1;
                state_next    = T5;
            end
            T5: state_next = T6;
            T6: begin
                cmd.a_sel  = A_PROD;
                cmd.b_sel  = B_C;
                state_next = T7;
            end
            T7: begin
                cmd.mul_go    = 1'b1;
                cmd.mul_first = 1'b1;
                state_next    = T8;
            end
            T8: begin
                cmd.mul_go = 1'b1;
                state_next = T9;
            end
            T9: state_next = T10;
            T10: begin
                cmd.sum_op = (s_reg < 3'd3) ? S_ADD : S_SUB;
                if (s_reg == 3'd5) begin
                    state_next = CWR;
                end else begin
                    s_next     = s_reg + 1'b1;
                    state_next = T1;
                end
            end
            CWR: begin
                cmd.cof_we   = 1'b1;
                cmd.cof_addr = i_reg;
                cmd.cof_neg  = i_reg[0] ^ i_reg[2];
                s_next       = '0;
                if (i_reg == IDX_W'(MAT_N - 1)) begin
                    j_next     = '0;
                    state_next = D1;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = T1;
                end
            end
            D1: begin
                cmd.rd_addr  = {2'b00, j_reg};
                cmd.cof_addr = {j_reg, 2'b00};
                if (j_reg == 2'd0) cmd.sum_op = S_CLR;
                state_next = D2;
            end
            D2: begin
                cmd.a_sel  = A_COF;
                cmd.b_sel  = B_MEM;
                state_next = D3;
            end
            D3: begin
                cmd.mul_go    = 1'b1;
                cmd.mul_first = 1'b1;
                state_next    = D4;
            end
            D4: begin
                cmd.mul_go = 1'b1;
                state_next = D5;
            end
            D5: begin
                cmd.mul_go = 1'b1;
                state_next = D6;
            end
            D6: begin
                cmd.mul_go = 1'b1;
                state_next = D7;
            end
            D7: state_next = D8;
            D8: begin
                cmd.sum_op = S_ADD;
                if (j_reg == 2'd3) begin
                    state_next = DLAT;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = D1;
                end
            end
            DLAT: begin
                cmd.det_ld = 1'b1;
                i_next     = '0;
                state_next = V1;
            end
            V1: begin
                cmd.cof_addr = i_reg;
                // skip the divide when the matrix is singular
                state_next   = stat.det_zero ? VOUT : V2;
            end
            V2: begin
                cmd.div_ld = 1'b1;
                step_next  = CW'(DATA_WIDTH - 1);
                state_next = VSTEP;
            end
            VSTEP: begin
                cmd.div_step = 1'b1;
                if (step_reg == '0) begin
                    state_next = VOUT;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            VOUT: begin
                cmd.out_ld   = 1'b1;
                cmd.out_idx  = i_reg;
                m_valid_next = 1'b1;
                state_next   = OUT;
            end
            OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (i_reg == IDX_W'(MAT_N - 1)) begin
                        i_next     = '0;
                        state_next = LOAD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = V1;
                    end
                end
            end
            default: state_next = LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= LOAD;
            cnt_reg     <= '0;
            i_reg       <= '0;
            s_reg       <= '0;
            j_reg       <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            i_reg       <= i_next;
            s_reg       <= s_next;
            j_reg       <= j_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hdl/matrix4_inverse_cofactor.sv =====
// Results are paced by one shared 33x32 multiplier that forms every cofactor and
// determinant term. Each result then passes the bit-serial divider (skipped when
// singular) and is held until taken; the next matrix loads only after the last
// result is taken. Elements load one a cycle while s_ready is high, only in the
// load state. Synchronous active-low reset returns to loading at element zero
// with no result pending.
module matrix4_inverse_cofactor import mi4_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VAL_W-1:0] s_element_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_inverse_value,
    output logic [IDX_W-1:0]        m_element_index,
    output logic                    m_singular,
    output logic                    m_saturated,
    output logic                    m_last_element
);

    mi4_cmd_t  cmd;
    mi4_stat_t stat;

    mi4_ctrl #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mi4_dpath #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .aclk            (aclk),
        .cmd             (cmd),
        .s_element_value (s_element_value),
        .stat            (stat),
        .m_inverse_value (m_inverse_value),
        .m_element_index (m_element_index),
        .m_singular      (m_singular),
        .m_saturated     (m_saturated),
        .m_last_element  (m_last_element)
    );

endmodule
